>>> rtl/ptmi_pkg.sv
`default_nettype none

package ptmi_pkg;

    // pool geometry
    localparam int PTMI_POOL_TABLES   = 64;
    localparam int PTMI_TABLE_ENTRIES = 512;
    localparam int PTMI_SLOT_W        = 9;

    // configuration port
    localparam int PTMI_CFG_W = 40;
    localparam logic PTMI_CFG_POOL_BASE  = 1'b0;
    localparam logic PTMI_CFG_FIRST_FREE = 1'b1;
    localparam logic [5:0] PTMI_FIRST_FREE_RST = 6'd2;

    // entry flag bits
    localparam logic [7:0] PTMI_FLAGS_4K = 8'h03;
    localparam logic [7:0] PTMI_FLAGS_2M = 8'h83;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_OUTSIDE   = 2'd2
    } t_status;

    typedef struct packed {
        logic [51:0] phys_addr;
        logic [47:0] virt_addr;
        logic        map_2m;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [63:0] leaf_entry;
        logic [5:0]  leaf_table;
        logic [8:0]  leaf_slot;
        logic [6:0]  tables_in_use;
    } t_rsp;

    // table store port control
    typedef struct packed {
        logic en;
        logic we;
    } t_mem_ctl;

endpackage

`default_nettype wire

>>> rtl/ptmi_ram.sv
`default_nettype none

module ptmi_ram
    import ptmi_pkg::*;
#(
    parameter int DEPTH = PTMI_POOL_TABLES * PTMI_TABLE_ENTRIES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire t_mem_ctl      i_ctl,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [63:0]   i_wdata,
    output logic [63:0]        o_rdata
);

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/ptmi_walk.sv
`default_nettype none

module ptmi_walk
    import ptmi_pkg::*;
#(
    parameter int POOL_TABLES = PTMI_POOL_TABLES,
    parameter int TW = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1,
    parameter int AW = TW + PTMI_SLOT_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_req                  i_req,
    output logic                       o_done,
    output t_rsp                       o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [PTMI_CFG_W-1:0] i_cfg_wdata,
    output t_mem_ctl                   o_mem_ctl,
    output logic [AW-1:0]              o_mem_addr,
    output logic [63:0]                o_mem_wdata,
    input  wire logic [63:0]           i_mem_rdata
);

    localparam int DEPTH = POOL_TABLES * PTMI_TABLE_ENTRIES;
    localparam int CW = $clog2(POOL_TABLES + 1);
    localparam int SW = ((CW > 6) ? CW : 6) + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WT,
        S_LEAF
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_clr;
    logic [AW-1:0]     r_addr;
    logic [TW-1:0]     r_tbl;
    logic [1:0]        r_lvl;
    logic [CW-1:0]     r_cnt;
    logic [39:0]       r_base;
    logic [5:0]        r_ff;
    t_req              r_req;
    t_rsp              r_rsp;
    logic              r_done;

    logic [8:0]        walk_slot;
    logic [8:0]        leaf_slot;
    logic [63:0]       leaf_val;
    logic [SW-1:0]     cand;
    logic              exhausted;
    logic              absent;
    logic [63:0]       new_entry;
    logic [39:0]       off;
    logic              outside;
    logic              walk_err;
    logic              last_lvl;
    logic [31:0]       cnt_ext;
    logic [31:0]       tbl_ext;

    // level index and leaf entry
    always_comb begin
        unique case (r_lvl)
            2'd0:    walk_slot = r_req.virt_addr[47:39];
            2'd1:    walk_slot = r_req.virt_addr[38:30];
            default: walk_slot = r_req.virt_addr[29:21];
        endcase
        if (r_req.map_2m) begin
            leaf_slot = r_req.virt_addr[29:21];
            leaf_val  = {12'b0, r_req.phys_addr[51:21], 13'b0, PTMI_FLAGS_2M};
        end else begin
            leaf_slot = r_req.virt_addr[20:12];
            leaf_val  = {12'b0, r_req.phys_addr[51:12], 4'b0, PTMI_FLAGS_4K};
        end
        last_lvl = r_req.map_2m ? (r_lvl == 2'd1) : (r_lvl == 2'd2);
    end

    // entry check: allocate when absent, range-check when present
    always_comb begin
        absent    = ~i_mem_rdata[0];
        cand      = SW'(r_ff) + SW'(r_cnt);
        exhausted = (cand >= SW'(POOL_TABLES));
        new_entry = {12'b0, r_base + 40'(cand), 4'b0, PTMI_FLAGS_4K};
        off       = i_mem_rdata[51:12] - r_base;
        outside   = (off >= 40'(POOL_TABLES));
        walk_err  = (absent && exhausted) || (!absent && outside);
        cnt_ext   = 32'(r_cnt);
        tbl_ext   = 32'(r_tbl);
    end

    // table store port
    always_comb begin
        o_mem_ctl   = '0;
        o_mem_addr  = r_addr;
        o_mem_wdata = new_entry;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_ctl   = '{en: 1'b1, we: 1'b1};
                o_mem_addr  = r_clr;
                o_mem_wdata = '0;
            end
            S_RD: begin
                o_mem_ctl  = '{en: 1'b1, we: 1'b0};
                o_mem_addr = {r_tbl, walk_slot};
            end
            S_WT: begin
                o_mem_ctl = '{en: absent & ~exhausted, we: absent & ~exhausted};
            end
            S_LEAF: begin
                o_mem_ctl   = '{en: 1'b1, we: 1'b1};
                o_mem_addr  = {r_tbl, leaf_slot};
                o_mem_wdata = leaf_val;
            end
            default: begin
                o_mem_ctl = '0;
            end
        endcase
    end

    // sequencer, configuration and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_base  <= '0;
            r_ff    <= PTMI_FIRST_FREE_RST;
            r_done  <= 1'b0;
            r_lvl   <= '0;
        end else begin
            r_done <= (r_state == S_LEAF) || ((r_state == S_WT) && walk_err);
            if (i_cfg_we) begin
                if (i_cfg_idx == PTMI_CFG_POOL_BASE) begin
                    r_base <= i_cfg_wdata[39:0];
                end else begin
                    r_ff <= i_cfg_wdata[5:0];
                end
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_tbl   <= '0;
                        r_lvl   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_addr  <= {r_tbl, walk_slot};
                    r_state <= S_WT;
                end
                S_WT: begin
                    if (walk_err) begin
                        r_rsp.status        <= absent ? ST_EXHAUSTED : ST_OUTSIDE;
                        r_rsp.leaf_entry    <= '0;
                        r_rsp.leaf_table    <= '0;
                        r_rsp.leaf_slot     <= '0;
                        r_rsp.tables_in_use <= cnt_ext[6:0];
                        r_state             <= S_IDLE;
                    end else begin
                        if (absent) begin
                            r_cnt <= r_cnt + 1'b1;
                            r_tbl <= cand[TW-1:0];
                        end else begin
                            r_tbl <= off[TW-1:0];
                        end
                        r_lvl   <= r_lvl + 1'b1;
                        r_state <= last_lvl ? S_LEAF : S_RD;
                    end
                end
                S_LEAF: begin
                    r_rsp.status        <= ST_DONE;
                    r_rsp.leaf_entry    <= leaf_val;
                    r_rsp.leaf_table    <= tbl_ext[5:0];
                    r_rsp.leaf_slot     <= leaf_slot;
                    r_rsp.tables_in_use <= cnt_ext[6:0];
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTHESIS
    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held");

    // allocation never runs past the pool
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(POOL_TABLES))
        else $error("allocation count past pool");

    // error results carry no leaf
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_rsp.status != ST_DONE) |->
        (r_rsp.leaf_entry == '0 && r_rsp.leaf_slot == '0))
        else $error("error result carries leaf");

    // walk never descends past the leaf level
    a_lvl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_lvl != 2'd3))
        else $error("walk level out of range");

    // a request is taken only once the clearing pass is over
    a_no_start_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (r_state == S_CLEAR || r_state == S_IDLE))
        else $error("walk started during clear");
`endif

endmodule

`default_nettype wire

>>> rtl/page_table_map_insert.sv
// channel  | ports                              | handshake
// ---------+------------------------------------+---------------------------------
// request  | i_req (t_req)                      | i_start high while o_busy low
// result   | o_rsp (t_rsp)                      | o_done strobe, one cycle
// config   | i_cfg_idx, i_cfg_wdata             | i_cfg_we, taken at once
//
// after reset a clearing pass zeroes all POOL_TABLES * 512 entries of the store,
// o_busy high meanwhile; config writes are taken during it
// a request takes a read, then a check and allocate, per walked level on the
// single-port table store, plus one leaf write; a 4 KiB page walks three
// levels, a 2 MiB page two
// the next request may be accepted in the cycle o_done is high; no result stall
`default_nettype none

module page_table_map_insert
    import ptmi_pkg::*;
#(
    parameter int POOL_TABLES = PTMI_POOL_TABLES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_req                  i_req,
    output logic                       o_done,
    output t_rsp                       o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [PTMI_CFG_W-1:0] i_cfg_wdata
);

    localparam int TW    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int AW    = TW + PTMI_SLOT_W;
    localparam int DEPTH = POOL_TABLES * PTMI_TABLE_ENTRIES;

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] mem_addr;
    logic [63:0]   mem_wdata;
    logic [63:0]   mem_rdata;

    // walk sequencer
    ptmi_walk #(
        .POOL_TABLES(POOL_TABLES),
        .TW         (TW),
        .AW         (AW)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_mem_ctl  (mem_ctl),
        .o_mem_addr (mem_addr),
        .o_mem_wdata(mem_wdata),
        .i_mem_rdata(mem_rdata)
    );

    // table store
    ptmi_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_ctl  (mem_ctl),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

endmodule

`default_nettype wire

>>> verif/tb_page_table_map_insert.sv
`default_nettype none

module tb_page_table_map_insert;
    import ptmi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_TABLES      = PTMI_POOL_TABLES;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic {JOB_MAP, JOB_CFG} t_job_kind;

    typedef struct {
        t_job_kind             kind;
        t_req                  req;
        logic                  cfg_idx;
        logic [PTMI_CFG_W-1:0] cfg_data;
        int                    idle_pct;
    } t_job;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    t_req                  i_req       = '0;
    logic                  i_cfg_we    = 1'b0;
    logic                  i_cfg_idx   = 1'b0;
    logic [PTMI_CFG_W-1:0] i_cfg_wdata = '0;
    logic                  o_busy;
    logic                  o_done;
    t_rsp                  o_rsp;

    page_table_map_insert i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // mirror of the table store and allocator
    logic [63:0] mirror_pt [0:N_TABLES*PTMI_TABLE_ENTRIES-1];
    logic [6:0]  alloc_mirror;
    logic [39:0] base_mirror;
    logic [5:0]  first_mirror;

    t_job job_q [$];
    t_rsp pending_rsp_q [$];
    int   n_mismatch = 0;

    // follow or create the pointer entry at one level of the walk
    function automatic t_status walk_level(input logic [5:0] tbl, input logic [8:0] slot,
                                           output logic [5:0] nxt);
        logic [63:0] ent;
        logic [6:0]  cand;
        logic [39:0] off;
        nxt = '0;
        ent = mirror_pt[{tbl, slot}];
        if (!ent[0]) begin
            cand = {1'b0, first_mirror} + alloc_mirror;
            if (cand >= N_TABLES)
                return ST_EXHAUSTED;
            ent = {12'h0, base_mirror + 40'(cand), 4'h0, PTMI_FLAGS_4K};
            mirror_pt[{tbl, slot}] = ent;
            alloc_mirror++;
        end
        off = ent[51:12] - base_mirror;
        if (off >= 40'(N_TABLES))
            return ST_OUTSIDE;
        nxt = off[5:0];
        return ST_DONE;
    endfunction

    // walk, allocate and write the leaf; returns the result the block should give
    function automatic t_rsp insert_mapping(input t_req r);
        t_rsp        rsp;
        t_status     st;
        logic [5:0]  tbl;
        logic [5:0]  nxt;
        logic [8:0]  slot;
        logic [63:0] leaf;
        rsp = '0;
        tbl = '0;
        st = walk_level(tbl, r.virt_addr[47:39], nxt);
        tbl = nxt;
        if (st == ST_DONE) begin
            st = walk_level(tbl, r.virt_addr[38:30], nxt);
            tbl = nxt;
        end
        if (st == ST_DONE && !r.map_2m) begin
            st = walk_level(tbl, r.virt_addr[29:21], nxt);
            tbl = nxt;
        end
        rsp.status        = st;
        rsp.tables_in_use = alloc_mirror;
        if (st == ST_DONE) begin
            if (r.map_2m) begin
                slot = r.virt_addr[29:21];
                leaf = {12'h0, r.phys_addr[51:21], 21'h0} | {56'h0, PTMI_FLAGS_2M};
            end else begin
                slot = r.virt_addr[20:12];
                leaf = {12'h0, r.phys_addr[51:12], 12'h0} | {56'h0, PTMI_FLAGS_4K};
            end
            mirror_pt[{tbl, slot}] = leaf;
            rsp.leaf_entry = leaf;
            rsp.leaf_table = tbl;
            rsp.leaf_slot  = slot;
        end
        return rsp;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        n_mismatch++;
    endtask

    function automatic logic [47:0] va_of(input logic [8:0] l4, input logic [8:0] l3,
                                          input logic [8:0] l2, input logic [8:0] l1,
                                          input logic [11:0] offs);
        return {l4, l3, l2, l1, offs};
    endfunction

    function automatic void push_map(input logic [51:0] pa, input logic [47:0] va,
                                     input logic big, input int pct);
        t_job j;
        j.kind          = JOB_MAP;
        j.req.phys_addr = pa;
        j.req.virt_addr = va;
        j.req.map_2m    = big;
        j.cfg_idx       = 1'b0;
        j.cfg_data      = '0;
        j.idle_pct      = pct;
        job_q.push_back(j);
    endfunction

    function automatic void push_cfg(input logic idx, input logic [PTMI_CFG_W-1:0] data);
        t_job j;
        j.kind     = JOB_CFG;
        j.req      = '0;
        j.cfg_idx  = idx;
        j.cfg_data = data;
        j.idle_pct = 0;
        job_q.push_back(j);
    endfunction

    // level index biased toward a few slots so that walks reuse existing tables
    function automatic logic [8:0] pick_level_idx();
        int r;
        r = $urandom_range(19);
        if (r < 14)
            return 9'd0;
        if (r < 16)
            return 9'd1;
        if (r < 18)
            return 9'd511;
        return 9'($urandom_range(511));
    endfunction

    function automatic void push_random_maps(input int count, input int pct);
        logic [63:0] raw;
        logic [51:0] pa;
        logic [47:0] va;
        for (int k = 0; k < count; k++) begin
            raw = {$urandom(), $urandom()};
            pa  = raw[51:0];
            // small 2 MiB frames so big leaves can land inside the pool
            if ($urandom_range(9) == 0)
                pa = {29'h0, 2'($urandom_range(3)), 21'($urandom())};
            raw = {$urandom(), $urandom()};
            if ($urandom_range(9) == 0)
                va = raw[47:0];
            else
                va = va_of(pick_level_idx(), pick_level_idx(), pick_level_idx(),
                           9'($urandom_range(511)), raw[11:0]);
            push_map(pa, va, $urandom_range(9) < 3, pct);
        end
    endfunction

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // request driver, fed from the job queue
    int   n_in_flight;
    int   n_quiet;
    logic took;
    logic nx_start;
    logic nx_we;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start     <= 1'b0;
            i_cfg_we    <= 1'b0;
            n_in_flight = 0;
            n_quiet     = 0;
        end else begin
            took = i_start && !o_busy;
            if (took)
                n_in_flight++;
            if (o_done)
                n_in_flight--;
            if (n_in_flight == 0 && !i_start)
                n_quiet++;
            else
                n_quiet = 0;
            nx_start = i_start && !took;
            nx_we    = 1'b0;
            if (!nx_start && job_q.size() != 0) begin
                if (job_q[0].kind == JOB_MAP) begin
                    if ($urandom_range(99) >= job_q[0].idle_pct) begin
                        i_req    <= job_q[0].req;
                        nx_start = 1'b1;
                        void'(job_q.pop_front());
                    end
                end else if (n_quiet >= SETTLE_CYCLES) begin
                    // register writes only once the block has gone quiet
                    i_cfg_idx   <= job_q[0].cfg_idx;
                    i_cfg_wdata <= job_q[0].cfg_data;
                    nx_we       = 1'b1;
                    void'(job_q.pop_front());
                end
            end
            i_start  <= nx_start;
            i_cfg_we <= nx_we;
        end
    end

    // monitor: check results, track config, predict each accepted request
    t_rsp want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_rsp_q.size() == 0) begin
                    flag_mismatch("result with no request outstanding");
                end else begin
                    want = pending_rsp_q.pop_front();
                    if (o_rsp.status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                o_rsp.status, want.status));
                    if (o_rsp.leaf_entry !== want.leaf_entry)
                        flag_mismatch($sformatf("leaf_entry got %h want %h",
                                                o_rsp.leaf_entry, want.leaf_entry));
                    if (o_rsp.leaf_table !== want.leaf_table)
                        flag_mismatch($sformatf("leaf_table got %0d want %0d",
                                                o_rsp.leaf_table, want.leaf_table));
                    if (o_rsp.leaf_slot !== want.leaf_slot)
                        flag_mismatch($sformatf("leaf_slot got %0d want %0d",
                                                o_rsp.leaf_slot, want.leaf_slot));
                    if (o_rsp.tables_in_use !== want.tables_in_use)
                        flag_mismatch($sformatf("tables_in_use got %0d want %0d",
                                                o_rsp.tables_in_use, want.tables_in_use));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == PTMI_CFG_POOL_BASE)
                    base_mirror = i_cfg_wdata[39:0];
                else if (i_cfg_idx == PTMI_CFG_FIRST_FREE)
                    first_mirror = i_cfg_wdata[5:0];
            end
            if (i_start && !o_busy)
                pending_rsp_q.push_back(insert_mapping(i_req));
        end
    end

    // stimulus and end of run
    initial begin
        for (int k = 0; k < N_TABLES * PTMI_TABLE_ENTRIES; k++)
            mirror_pt[k] = '0;
        alloc_mirror = '0;
        base_mirror  = '0;
        first_mirror = PTMI_FIRST_FREE_RST;

        // directed part
        push_cfg(PTMI_CFG_POOL_BASE, 40'h0);
        push_cfg(PTMI_CFG_FIRST_FREE, 40'd2);
        // fresh walks at the lowest and highest addresses
        push_map(52'hF_FFFF_FFFF_FFFF, 48'h0, 1'b0, 0);
        push_map(52'h0, 48'hFFFF_FFFF_FFFF, 1'b0, 0);
        // big page written over a pointer to a level-one table
        push_map(52'hF_FFFF_FFFF_FFFF, 48'h0, 1'b1, 0);
        // small walk meets that big leaf, its frame lies outside the pool
        push_map(52'h0_0000_0000_1234, 48'h0, 1'b0, 0);
        // big leaf with frame zero, then a small walk through it into the root table
        push_map(52'h0, va_of(9'd1, 9'd0, 9'd0, 9'd0, 12'h0), 1'b1, 0);
        push_map(52'hA_BCDE_F012_3456, va_of(9'd1, 9'd0, 9'd0, 9'd5, 12'hFFF), 1'b0, 0);
        // root slot now holds a leaf, following it leaves the pool
        push_map(52'h1_0000_0000_0000, va_of(9'd5, 9'd3, 9'd2, 9'd1, 12'h0), 1'b0, 0);
        // leaf overwrite, low address bits ignored
        push_map(52'h0_0000_0000_1FFF, 48'hFFFF_FFFF_FFFF, 1'b0, 0);
        push_map(52'hF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 0);
        push_map(52'h5_5555_5555_5555, 48'hFFFF_FFFF_FFFF, 1'b0, 0);
        // pool exhausted at once
        push_cfg(PTMI_CFG_FIRST_FREE, 40'd63);
        push_map(52'h0_0000_0012_3000, va_of(9'd300, 9'd0, 9'd0, 9'd0, 12'h0), 1'b0, 0);
        // exhausted part way through the walk, tables taken so far stay taken
        push_cfg(PTMI_CFG_FIRST_FREE, 40'd54);
        push_map(52'h0_0000_0045_6000, va_of(9'd300, 9'd0, 9'd0, 9'd0, 12'h0), 1'b0, 0);
        push_map(52'h0_0000_0045_6000, va_of(9'd300, 9'd0, 9'd0, 9'd7, 12'h0), 1'b0, 0);
        // allocation hands out tables already in use, contents kept
        push_cfg(PTMI_CFG_FIRST_FREE, 40'd52);
        push_map(52'h0_0000_0078_9000, va_of(9'd400, 9'd0, 9'd0, 9'd9, 12'h0), 1'b0, 0);
        push_map(52'h0_0000_0078_9000, va_of(9'd400, 9'd0, 9'd0, 9'd0, 12'h0), 1'b1, 0);

        // random part, sender idles often
        push_cfg(PTMI_CFG_FIRST_FREE, 40'd1);
        push_random_maps(370, 36);
        // pool moved near the top of the frame space, old pointers shift
        push_cfg(PTMI_CFG_POOL_BASE, 40'hFF_FFFF_FFF0);
        push_cfg(PTMI_CFG_FIRST_FREE, 40'd0);
        push_random_maps(370, 88);
        push_cfg(PTMI_CFG_POOL_BASE, 40'hFF_FFFF_FFFF);
        push_cfg(PTMI_CFG_FIRST_FREE, 40'd63);
        push_random_maps(30, 0);
        push_cfg(PTMI_CFG_POOL_BASE, 40'h0);
        push_cfg(PTMI_CFG_FIRST_FREE, 40'd2);
        push_random_maps(330, 0);

        // reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all requests taken and all results checked
        while (job_q.size() != 0 || i_start || pending_rsp_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/ptmi_pkg.sv
rtl/ptmi_ram.sv
rtl/ptmi_walk.sv
rtl/page_table_map_insert.sv
verif/tb_page_table_map_insert.sv
